// File: hdl/pan_tilt_telemetry_parser_assert.svh
// Assertion macros for the pan/tilt telemetry parser.
// Each macro expects signals named clk and rst in the using module.
`ifndef PAN_TILT_TELEMETRY_PARSER_ASSERT_SVH
`define PAN_TILT_TELEMETRY_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

`define PTT_ASSERT_IMP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pan/tilt parser assertion failed");

`define PTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pan/tilt parser assertion failed");

`else

`define PTT_ASSERT_IMP(lbl, prop)

`define PTT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/ptt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

  localparam int NUM_W = 23;
  localparam int DEN_W = 16;
  localparam logic [4:0] DIV_STEPS = 5'(NUM_W);

  localparam logic [7:0] CH_PAN  = 8'h50;
  localparam logic [7:0] CH_TILT = 8'h54;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_HOME = 8'h4B;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;
  localparam logic [7:0] CH_A    = 8'd65;

  localparam logic [2:0] CFG_PAN_0   = 3'd0;
  localparam logic [2:0] CFG_PAN_90  = 3'd1;
  localparam logic [2:0] CFG_PAN_180 = 3'd2;
  localparam logic [2:0] CFG_PAN_270 = 3'd3;
  localparam logic [2:0] CFG_PAN_360 = 3'd4;
  localparam logic [2:0] CFG_TILT_0  = 3'd5;
  localparam logic [2:0] CFG_TILT_90 = 3'd6;

  localparam logic [15:0] RST_PAN_0   = 16'd1000;
  localparam logic [15:0] RST_PAN_90  = 16'd1250;
  localparam logic [15:0] RST_PAN_180 = 16'd1500;
  localparam logic [15:0] RST_PAN_270 = 16'd1750;
  localparam logic [15:0] RST_PAN_360 = 16'd2000;
  localparam logic [15:0] RST_TILT_0  = 16'd1000;
  localparam logic [15:0] RST_TILT_90 = 16'd2000;

  localparam logic [8:0] HDG_BASE_0   = 9'd0;
  localparam logic [8:0] HDG_BASE_90  = 9'd90;
  localparam logic [8:0] HDG_BASE_180 = 9'd180;
  localparam logic [8:0] HDG_BASE_270 = 9'd270;
  localparam logic [6:0] SLOPE_SHORT  = 7'd89;
  localparam logic [6:0] SLOPE_LONG   = 7'd90;
  localparam logic [6:0] TILT_MAX     = 7'd90;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_PAN,
    FS_TILT,
    FS_SUM
  } ptt_field_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } ptt_state_t;

  typedef struct packed {
    logic accept;
    logic sel;
    logic start;
    logic step;
    logic load_out;
  } ptt_cmd_t;

endpackage

`default_nettype wire

// File: hdl/ptt_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_div (
  input  wire logic                       clk,
  input  wire logic                       start,
  input  wire logic                       step,
  input  wire logic [ptt_pkg::NUM_W-1:0]  num,
  input  wire logic [ptt_pkg::DEN_W-1:0]  den,
  output logic      [ptt_pkg::NUM_W-1:0]  quo
);

  logic [ptt_pkg::NUM_W-1:0] dvd_q;
  logic [ptt_pkg::DEN_W-1:0] rem;
  logic [ptt_pkg::DEN_W-1:0] den_r;
  logic [ptt_pkg::DEN_W:0]   rem_sh;
  logic [ptt_pkg::DEN_W:0]   diff;
  logic                      fits;

  assign rem_sh = {rem, dvd_q[ptt_pkg::NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = rem_sh >= {1'b0, den_r};
  assign quo    = dvd_q;

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_q <= num;
      rem   <= '0;
      den_r <= den;
    end else if (step) begin
      dvd_q <= {dvd_q[ptt_pkg::NUM_W-2:0], fits};
      rem   <= fits ? diff[ptt_pkg::DEN_W-1:0] : rem_sh[ptt_pkg::DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hdl/ptt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_valid,
  output logic                   s_ready,
  output logic                   m_valid,
  input  wire logic              m_ready,
  output ptt_pkg::ptt_cmd_t      cmd
);

  ptt_pkg::ptt_state_t state;
  ptt_pkg::ptt_state_t state_next;
  logic [4:0]          step_cnt;
  logic [4:0]          step_cnt_next;
  logic                out_valid;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptt_pkg::ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_ready    = 1'b0;
    unique case (state)
      ptt_pkg::ST_IDLE: begin
        s_ready = 1'b1;
        if (s_valid) begin
          cmd.accept = 1'b1;
          state_next = ptt_pkg::ST_SEL;
        end
      end
      ptt_pkg::ST_SEL: begin
        cmd.sel    = 1'b1;
        state_next = ptt_pkg::ST_MUL;
      end
      ptt_pkg::ST_MUL: begin
        cmd.start  = 1'b1;
        state_next = ptt_pkg::ST_DIV;
      end
      ptt_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (step_cnt == ptt_pkg::DIV_STEPS - 5'd1) begin
          state_next = ptt_pkg::ST_FIN;
        end
      end
      ptt_pkg::ST_FIN: begin
        if (!out_valid || m_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ptt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ptt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    step_cnt_next = step_cnt;
    if (cmd.start) begin
      step_cnt_next = '0;
    end else if (cmd.step) begin
      step_cnt_next = step_cnt + 5'd1;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (m_ready) begin
      out_valid_next = 1'b0;
    end
  end

  assign m_valid = out_valid;

`include "pan_tilt_telemetry_parser_assert.svh"

  `PTT_ASSERT_NEXT(a_accept_to_sel, s_valid && s_ready, state == ptt_pkg::ST_SEL)
  `PTT_ASSERT_IMP(a_load_when_free, cmd.load_out |-> (!out_valid || m_ready))
  `PTT_ASSERT_IMP(a_step_range, (state == ptt_pkg::ST_DIV) |-> (step_cnt < ptt_pkg::DIV_STEPS))
  `PTT_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid)

endmodule

`default_nettype wire

// File: hdl/ptt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ptt_pkg::ptt_cmd_t cmd,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              cfg_wr,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output logic                   fix_event,
  output logic                   home_event,
  output logic [8:0]             heading_deg,
  output logic [6:0]             tilt_deg
);

  logic [15:0] p0, p90, p180, p270, p360, t0, t90;

  ptt_pkg::ptt_field_t field_state, field_state_next;
  logic [15:0] pan_pulse, pan_pulse_next;
  logic [15:0] tilt_pulse, tilt_pulse_next;
  logic [7:0]  received_sum, received_sum_next;
  logic [7:0]  computed_sum, computed_sum_next;
  logic [1:0]  hex_digit_count, hex_digit_count_next;
  logic        fix_flag, fix_flag_next;
  logic        home_flag, home_flag_next;

  logic [15:0] pan_dec, tilt_dec;
  logic [7:0]  hex_d;

  logic [15:0] h_a, h_b;
  logic [8:0]  h_base;
  logic        h_long, h_oor;
  logic [16:0] t_diff, t_den;
  logic [15:0] h_a_sel, h_b_sel;
  logic [8:0]  h_base_sel;
  logic        h_long_sel;

  logic        h_zero, t_zero, t_neg;
  logic [15:0] h_dx, h_den;
  logic [15:0] t_mag, t_den_mag;
  logic [16:0] t_diff_neg, t_den_neg;
  logic [ptt_pkg::NUM_W-1:0] h_num, t_num;
  logic [ptt_pkg::NUM_W-1:0] h_quo, t_quo;

  logic [8:0]  heading_val;
  logic [6:0]  tilt_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0   <= ptt_pkg::RST_PAN_0;
      p90  <= ptt_pkg::RST_PAN_90;
      p180 <= ptt_pkg::RST_PAN_180;
      p270 <= ptt_pkg::RST_PAN_270;
      p360 <= ptt_pkg::RST_PAN_360;
      t0   <= ptt_pkg::RST_TILT_0;
      t90  <= ptt_pkg::RST_TILT_90;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        ptt_pkg::CFG_PAN_0:   p0   <= cfg_data;
        ptt_pkg::CFG_PAN_90:  p90  <= cfg_data;
        ptt_pkg::CFG_PAN_180: p180 <= cfg_data;
        ptt_pkg::CFG_PAN_270: p270 <= cfg_data;
        ptt_pkg::CFG_PAN_360: p360 <= cfg_data;
        ptt_pkg::CFG_TILT_0:  t0   <= cfg_data;
        ptt_pkg::CFG_TILT_90: t90  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign pan_dec  = pan_pulse * 16'd10 + {8'd0, rx_byte} - {8'd0, ptt_pkg::CH_ZERO};
  assign tilt_dec = tilt_pulse * 16'd10 + {8'd0, rx_byte} - {8'd0, ptt_pkg::CH_ZERO};
  assign hex_d    = (rx_byte >= ptt_pkg::CH_ZERO && rx_byte <= ptt_pkg::CH_NINE) ?
                    rx_byte - ptt_pkg::CH_ZERO : rx_byte - ptt_pkg::CH_A + 8'd10;

  always_comb begin
    field_state_next     = field_state;
    pan_pulse_next       = pan_pulse;
    tilt_pulse_next      = tilt_pulse;
    received_sum_next    = received_sum;
    computed_sum_next    = computed_sum;
    hex_digit_count_next = hex_digit_count;
    fix_flag_next        = 1'b0;
    home_flag_next       = 1'b0;
    priority if (rx_byte == ptt_pkg::CH_PAN) begin
      pan_pulse_next       = '0;
      field_state_next     = ptt_pkg::FS_PAN;
      received_sum_next    = '0;
      computed_sum_next    = ptt_pkg::CH_PAN;
      hex_digit_count_next = '0;
    end else if (rx_byte == ptt_pkg::CH_TILT) begin
      tilt_pulse_next   = '0;
      field_state_next  = ptt_pkg::FS_TILT;
      computed_sum_next = computed_sum ^ ptt_pkg::CH_TILT;
    end else if (rx_byte == ptt_pkg::CH_STAR) begin
      hex_digit_count_next = '0;
      field_state_next     = ptt_pkg::FS_SUM;
    end else if (hex_digit_count == 2'd2) begin
      fix_flag_next    = (computed_sum == received_sum);
      field_state_next = ptt_pkg::FS_IDLE;
    end else if (rx_byte == ptt_pkg::CH_HOME) begin
      home_flag_next = 1'b1;
    end else if (field_state == ptt_pkg::FS_PAN) begin
      pan_pulse_next    = pan_dec;
      computed_sum_next = computed_sum ^ rx_byte;
    end else if (field_state == ptt_pkg::FS_TILT) begin
      tilt_pulse_next   = tilt_dec;
      computed_sum_next = computed_sum ^ rx_byte;
    end else if (field_state == ptt_pkg::FS_SUM) begin
      received_sum_next    = {received_sum[3:0], 4'd0} + hex_d;
      hex_digit_count_next = hex_digit_count + 2'd1;
    end else begin
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_state     <= ptt_pkg::FS_IDLE;
      pan_pulse       <= '0;
      tilt_pulse      <= '0;
      received_sum    <= '0;
      computed_sum    <= '0;
      hex_digit_count <= '0;
      fix_flag        <= 1'b0;
      home_flag       <= 1'b0;
    end else if (cmd.accept) begin
      field_state     <= field_state_next;
      pan_pulse       <= pan_pulse_next;
      tilt_pulse      <= tilt_pulse_next;
      received_sum    <= received_sum_next;
      computed_sum    <= computed_sum_next;
      hex_digit_count <= hex_digit_count_next;
      fix_flag        <= fix_flag_next;
      home_flag       <= home_flag_next;
    end
  end

  always_comb begin
    priority if (pan_pulse < p90) begin
      h_a_sel    = p0;
      h_b_sel    = p90 - 16'd1;
      h_base_sel = ptt_pkg::HDG_BASE_0;
      h_long_sel = 1'b0;
    end else if (pan_pulse < p180) begin
      h_a_sel    = p90;
      h_b_sel    = p180 - 16'd1;
      h_base_sel = ptt_pkg::HDG_BASE_90;
      h_long_sel = 1'b0;
    end else if (pan_pulse < p270) begin
      h_a_sel    = p180;
      h_b_sel    = p270 - 16'd1;
      h_base_sel = ptt_pkg::HDG_BASE_180;
      h_long_sel = 1'b0;
    end else begin
      h_a_sel    = p270;
      h_b_sel    = p360;
      h_base_sel = ptt_pkg::HDG_BASE_270;
      h_long_sel = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      h_a    <= h_a_sel;
      h_b    <= h_b_sel;
      h_base <= h_base_sel;
      h_long <= h_long_sel;
      h_oor  <= (pan_pulse < p0) || (pan_pulse > p360);
      t_diff <= {1'b0, tilt_pulse} - {1'b0, t0};
      t_den  <= {1'b0, t90} - {1'b0, t0};
    end
  end

  assign h_dx       = pan_pulse - h_a;
  assign h_den      = h_b - h_a;
  assign t_diff_neg = ~t_diff + 17'd1;
  assign t_den_neg  = ~t_den + 17'd1;
  assign t_mag      = t_diff[16] ? t_diff_neg[15:0] : t_diff[15:0];
  assign t_den_mag  = t_den[16] ? t_den_neg[15:0] : t_den[15:0];
  assign h_num      = ptt_pkg::NUM_W'(h_dx) * ptt_pkg::NUM_W'(h_long ? ptt_pkg::SLOPE_LONG
                                                               : ptt_pkg::SLOPE_SHORT);
  assign t_num      = ptt_pkg::NUM_W'(t_mag) * ptt_pkg::NUM_W'(ptt_pkg::TILT_MAX);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      h_zero <= (h_den == 16'd0);
      t_zero <= (t_den == 17'd0);
      t_neg  <= t_diff[16] ^ t_den[16];
    end
  end

  ptt_div u_hdg_div (
    .clk   (clk),
    .start (cmd.start),
    .step  (cmd.step),
    .num   (h_num),
    .den   (h_den),
    .quo   (h_quo)
  );

  ptt_div u_tilt_div (
    .clk   (clk),
    .start (cmd.start),
    .step  (cmd.step),
    .num   (t_num),
    .den   (t_den_mag),
    .quo   (t_quo)
  );

  always_comb begin
    priority if (h_oor) begin
      heading_val = '0;
    end else if (h_zero) begin
      heading_val = h_base;
    end else begin
      heading_val = h_base + {2'd0, h_quo[6:0]};
    end
  end

  always_comb begin
    priority if (t_zero || t_neg) begin
      tilt_val = '0;
    end else if (t_quo > ptt_pkg::NUM_W'(ptt_pkg::TILT_MAX)) begin
      tilt_val = ptt_pkg::TILT_MAX;
    end else begin
      tilt_val = t_quo[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      fix_event   <= fix_flag;
      home_event  <= home_flag;
      heading_deg <= heading_val;
      tilt_deg    <= tilt_val;
    end
  end

endmodule

`default_nettype wire

// File: hdl/pan_tilt_telemetry_parser.sv
// Each byte runs through the select, multiply and divide states (the 23 steps of the radix-2
// map dividers) and the finish state, which loads the result when the output register is free.
// Only then is the next byte taken, also while the previous result waits in the output register.
// Reset (rst, synchronous, active high) clears the frame state and loads the default
// pulse widths for all seven map registers; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module pan_tilt_telemetry_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [0] fix_event, [1] home_event,
                                           // [10:2] heading_deg, [17:11] tilt_deg
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  ptt_pkg::ptt_cmd_t cmd;
  logic              fix_event;
  logic              home_event;
  logic [8:0]        heading_deg;
  logic [6:0]        tilt_deg;

  assign cfg_ready = 1'b1;

  ptt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .cmd     (cmd)
  );

  ptt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rx_byte     (s_axis_tdata),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fix_event   (fix_event),
    .home_event  (home_event),
    .heading_deg (heading_deg),
    .tilt_deg    (tilt_deg)
  );

  assign m_axis_tdata = {6'd0, tilt_deg, heading_deg, home_event, fix_event};

endmodule

`default_nettype wire

// File: test/pan_tilt_telemetry_parser_checker.sv
`timescale 1ns / 1ps

module pan_tilt_telemetry_parser_checker
  import ptt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_ready,
  input  logic [7:0]  rx_data,
  input  logic        tm_valid,
  input  logic        tm_ready,
  input  logic [23:0] tm_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          waiting
);

  typedef struct packed {
    logic       fix;
    logic       home;
    logic [8:0] heading;
    logic [6:0] tilt;
  } telemetry_t;

  telemetry_t  telemetry_q[$];
  logic [15:0] map_reg[7];
  ptt_field_t  field;
  logic [15:0] pan_width;
  logic [15:0] tilt_width;
  logic [7:0]  sum_rx;
  logic [7:0]  sum_calc;
  logic [1:0]  hex_count;

  function automatic longint scale(input longint x, input longint a, input longint b,
                                   input longint y0, input longint y1);
    if (b == a) return y0;
    return (x - a) * (y1 - y0) / (b - a) + y0;
  endfunction

  function automatic logic [8:0] pan_heading();
    longint x, p0, p90, p180, p270, p360, h;
    x    = pan_width;
    p0   = map_reg[CFG_PAN_0];
    p90  = map_reg[CFG_PAN_90];
    p180 = map_reg[CFG_PAN_180];
    p270 = map_reg[CFG_PAN_270];
    p360 = map_reg[CFG_PAN_360];
    if (x < p0 || x > p360) h = 0;
    else if (x < p90) h = scale(x, p0, p90 - 1, 0, 89);
    else if (x < p180) h = scale(x, p90, p180 - 1, 90, 179);
    else if (x < p270) h = scale(x, p180, p270 - 1, 180, 269);
    else h = scale(x, p270, p360, 270, 360);
    return h[8:0];
  endfunction

  function automatic logic [6:0] tilt_angle();
    longint v;
    v = scale(tilt_width, map_reg[CFG_TILT_0], map_reg[CFG_TILT_90], 0, 90);
    if (v < 0) v = 0;
    if (v > 90) v = 90;
    return v[6:0];
  endfunction

  // Advances the frame state by one byte and returns the telemetry it yields.
  function automatic telemetry_t decode_byte(input logic [7:0] b);
    telemetry_t r;
    logic [7:0] digit;
    r = '0;
    if (b == CH_PAN) begin
      pan_width = '0;
      field     = FS_PAN;
      sum_rx    = '0;
      sum_calc  = CH_PAN;
      hex_count = '0;
    end else if (b == CH_TILT) begin
      tilt_width = '0;
      field      = FS_TILT;
      sum_calc   = sum_calc ^ CH_TILT;
    end else if (b == CH_STAR) begin
      hex_count = '0;
      field     = FS_SUM;
    end else if (hex_count == 2'd2) begin
      r.fix = (sum_calc == sum_rx);
      field = FS_IDLE;
    end else if (b == CH_HOME) begin
      r.home = 1'b1;
    end else begin
      case (field)
        FS_PAN: begin
          pan_width = pan_width * 16'd10 + {8'd0, b} - {8'd0, CH_ZERO};
          sum_calc  = sum_calc ^ b;
        end
        FS_TILT: begin
          tilt_width = tilt_width * 16'd10 + {8'd0, b} - {8'd0, CH_ZERO};
          sum_calc   = sum_calc ^ b;
        end
        FS_SUM: begin
          digit     = (b >= CH_ZERO && b <= CH_NINE) ? b - CH_ZERO : b - CH_A + 8'd10;
          sum_rx    = {sum_rx[3:0], 4'h0} + digit;
          hex_count = hex_count + 2'd1;
        end
        default: begin
        end
      endcase
    end
    r.heading = pan_heading();
    r.tilt    = tilt_angle();
    return r;
  endfunction

  always @(posedge clk) begin
    telemetry_t want;
    telemetry_t got;
    if (rst) begin
      telemetry_q.delete();
      map_reg[CFG_PAN_0]   = RST_PAN_0;
      map_reg[CFG_PAN_90]  = RST_PAN_90;
      map_reg[CFG_PAN_180] = RST_PAN_180;
      map_reg[CFG_PAN_270] = RST_PAN_270;
      map_reg[CFG_PAN_360] = RST_PAN_360;
      map_reg[CFG_TILT_0]  = RST_TILT_0;
      map_reg[CFG_TILT_90] = RST_TILT_90;
      field      = FS_IDLE;
      pan_width  = '0;
      tilt_width = '0;
      sum_rx     = '0;
      sum_calc   = '0;
      hex_count  = '0;
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= CFG_TILT_90) begin
        map_reg[cfg_index] = cfg_data;
      end
      if (rx_valid && rx_ready) begin
        telemetry_q.push_back(decode_byte(rx_data));
      end
      if (tm_valid && tm_ready) begin
        got.fix     = tm_data[0];
        got.home    = tm_data[1];
        got.heading = tm_data[10:2];
        got.tilt    = tm_data[17:11];
        if (telemetry_q.size() == 0) begin
          $error("telemetry transfer with nothing expected: 0x%06h", tm_data);
          mismatches++;
        end else begin
          want = telemetry_q.pop_front();
          if (got.fix !== want.fix) begin
            $error("fix_event: expected %0d, actual %0d", want.fix, got.fix);
            mismatches++;
          end
          if (got.home !== want.home) begin
            $error("home_event: expected %0d, actual %0d", want.home, got.home);
            mismatches++;
          end
          if (got.heading !== want.heading) begin
            $error("heading_deg: expected %0d, actual %0d", want.heading, got.heading);
            mismatches++;
          end
          if (got.tilt !== want.tilt) begin
            $error("tilt_deg: expected %0d, actual %0d", want.tilt, got.tilt);
            mismatches++;
          end
        end
      end
    end
    waiting = telemetry_q.size();
  end

endmodule

// File: test/pan_tilt_telemetry_parser_tb.sv
`timescale 1ns / 1ps

module pan_tilt_telemetry_parser_tb;
  import ptt_pkg::*;

  localparam int NUM_PHASES = 7;
  localparam int ITEMS      = 1950;
  localparam int SETTLE     = 40;
  localparam int LIMIT      = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic        calm = 1'b0;
  int          items_sent = 0;
  int          cycles = 0;
  int          mismatches;
  int          waiting;
  logic [15:0] map_setting[7];

  pan_tilt_telemetry_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pan_tilt_telemetry_parser_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (s_axis_tvalid),
    .rx_ready   (s_axis_tready),
    .rx_data    (s_axis_tdata),
    .tm_valid   (m_axis_tvalid),
    .tm_ready   (m_axis_tready),
    .tm_data    (m_axis_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 6);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_ZERO + n : CH_A + n - 8'd10;
  endfunction

  function automatic logic [7:0] frame_sum(input string pan_s, input string tilt_s);
    logic [7:0] s;
    s = CH_PAN ^ CH_TILT;
    for (int i = 0; i < pan_s.len(); i++) s = s ^ pan_s[i];
    for (int i = 0; i < tilt_s.len(); i++) s = s ^ tilt_s[i];
    return s;
  endfunction

  // Mostly widths inside the mapped span, with its edges, full 16-bit values
  // and values that wrap now and then.
  function automatic int pick_width(input int lo, input int hi);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 6) v = $urandom_range(lo, hi);
    else if (r == 6) begin
      case ($urandom_range(0, 3))
        0: v = lo - 1;
        1: v = lo;
        2: v = hi;
        default: v = hi + 1;
      endcase
      if (v < 0) v = 0;
    end else if (r < 9) v = $urandom_range(0, 65535);
    else v = $urandom_range(0, 999999);
    return v;
  endfunction

  task automatic choose_setting(input int phase);
    case (phase)
      0: map_setting = '{16'd1000, 16'd1250, 16'd1500, 16'd1750, 16'd2000,
                         16'd1000, 16'd2000};
      1: map_setting = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      2: map_setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF};
      3: map_setting = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535,
                         16'd0, 16'd65535};
      4: map_setting = '{16'd3000, 16'd2000, 16'd2500, 16'd1000, 16'd4000,
                         16'd2000, 16'd1000};
      5: map_setting = '{16'd500, 16'd500, 16'd900, 16'd900, 16'd1300,
                         16'd700, 16'd700};
      default: begin
        for (int i = CFG_PAN_0; i <= CFG_TILT_90; i++) begin
          map_setting[i] = 16'($urandom_range(0, 65535));
        end
      end
    endcase
  endtask

  task automatic load_maps();
    for (int i = CFG_PAN_0; i <= CFG_TILT_90; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= map_setting[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_frame();
    logic [7:0] frame_q[$];
    logic [7:0] sum;
    string      pan_s;
    string      tilt_s;
    int         lo;
    int         hi;
    int         flaw;
    lo = 65535;
    hi = 0;
    for (int i = CFG_PAN_0; i <= CFG_PAN_360; i++) begin
      if (map_setting[i] < lo) lo = map_setting[i];
      if (map_setting[i] > hi) hi = map_setting[i];
    end
    pan_s  = $sformatf("%0d", pick_width(lo, hi));
    tilt_s = $sformatf("%0d", pick_width(map_setting[CFG_TILT_0], map_setting[CFG_TILT_90]));
    sum    = frame_sum(pan_s, tilt_s);
    flaw   = $urandom_range(0, 9);
    if (flaw == 0) sum = sum ^ 8'($urandom_range(1, 255));
    frame_q.push_back(CH_PAN);
    for (int i = 0; i < pan_s.len(); i++) frame_q.push_back(pan_s[i]);
    frame_q.push_back(CH_TILT);
    for (int i = 0; i < tilt_s.len(); i++) frame_q.push_back(tilt_s[i]);
    frame_q.push_back(CH_STAR);
    frame_q.push_back(hex_char(sum[7:4]));
    frame_q.push_back(hex_char(sum[3:0]));
    case ($urandom_range(0, 2))
      0: frame_q.push_back(CH_HOME);
      1: frame_q.push_back(8'h0D);
      default: frame_q.push_back(8'($urandom_range(0, 255)));
    endcase
    if (flaw == 1) begin
      lo = $urandom_range(1, frame_q.size() - 1);
      while (frame_q.size() > lo) void'(frame_q.pop_back());
    end else if (flaw == 2) begin
      frame_q.insert($urandom_range(1, frame_q.size() - 1), 8'($urandom_range(0, 255)));
    end else if (flaw == 3) begin
      frame_q.insert($urandom_range(1, frame_q.size() - 1), CH_HOME);
    end
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  initial begin
    logic [7:0] sum;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      choose_setting(p);
      load_maps();
      calm = (p == 3);
      if (p == 0) begin
        send_byte(CH_HOME);
        send_byte(8'h00);
        send_byte(CH_PAN);
        send_text("2000");
        send_byte(CH_TILT);
        send_text("1500");
        send_byte(CH_STAR);
        sum = frame_sum("2000", "1500");
        send_byte(hex_char(sum[7:4]));
        send_byte(hex_char(sum[3:0]));
        send_byte(CH_HOME);
        send_byte(CH_HOME);
        send_byte(8'hFF);
        send_byte(CH_PAN);
        send_byte(8'hFF);
        send_byte(CH_TILT);
        send_byte(8'h00);
        send_byte(CH_STAR);
        send_byte("z");
        send_byte(8'h80);
      end
      while (items_sent < (p + 1) * ITEMS / NUM_PHASES) begin
        if ($urandom_range(0, 99) < 80) begin
          send_frame();
        end else begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
      end
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while (waiting != 0) @(posedge clk);
      repeat (SETTLE) @(posedge clk);
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/ptt_pkg.sv
hdl/ptt_div.sv
hdl/ptt_ctrl.sv
hdl/ptt_dp.sv
hdl/pan_tilt_telemetry_parser.sv
test/pan_tilt_telemetry_parser_checker.sv
test/pan_tilt_telemetry_parser_tb.sv
